// ===== src/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// srp_pkg
// Shared constants, types and tables of the stepper ring positioner.
// ----------------------------------------------------------------------------
package srp_pkg;

   localparam int STEPS_PER_TURN = 200;
   localparam int RAMP_LENGTH    = 5;
   localparam int RAMP_DEPTH     = 5;

   localparam int POS_WIDTH      = 8;
   localparam int DELAY_WIDTH    = 8;
   localparam int COIL_WIDTH     = 6;
   localparam int PHASE_WIDTH    = 2;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int RAMP_IDX_WIDTH = $clog2(RAMP_DEPTH);

   typedef logic [POS_WIDTH-1:0]   pos_type;
   typedef logic [DELAY_WIDTH-1:0] delay_type;
   typedef logic [COIL_WIDTH-1:0]  coil_type;
   typedef logic [PHASE_WIDTH-1:0] phase_type;

   localparam pos_type LAST_POS  = pos_type'(STEPS_PER_TURN - 1);
   localparam pos_type HALF_TURN = pos_type'(STEPS_PER_TURN / 2);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FULL_SPEED_DELAY = 3'd0,
      CSR_RAMP_DELAY_0     = 3'd1,
      CSR_RAMP_DELAY_1     = 3'd2,
      CSR_RAMP_DELAY_2     = 3'd3,
      CSR_RAMP_DELAY_3     = 3'd4,
      CSR_RAMP_DELAY_4     = 3'd5
   } csr_index_type;

   localparam delay_type FULL_SPEED_RESET = 8'd6;
   localparam delay_type RAMP_RESET [RAMP_DEPTH] = '{8'd20, 8'd16, 8'd12, 8'd9, 8'd7};

   function automatic coil_type coil_pattern(input phase_type phase);
      coil_type pattern;
      case (phase)
         2'd0: pattern = 6'b110110;
         2'd1: pattern = 6'b101110;
         2'd2: pattern = 6'b101101;
         2'd3: pattern = 6'b110101;
         default: pattern = 6'b110110;
      endcase
      return pattern;
   endfunction

   function automatic pos_type abs_gap(input pos_type a, input pos_type b);
      return (a > b) ? pos_type'(a - b) : pos_type'(b - a);
   endfunction

   function automatic pos_type folded_distance(input pos_type a, input pos_type b);
      pos_type d;
      d = abs_gap(a, b);
      if (d > HALF_TURN) begin
         d = pos_type'((POS_WIDTH+1)'(STEPS_PER_TURN) - {1'b0, d});
      end
      return d;
   endfunction

endpackage

// ===== src/stepper_ring_positioner_top.sv =====
// ----------------------------------------------------------------------------
// stepper_ring_positioner_top
// Full-step stepper positioner on a ring with shortest-way moves and a ramp.
//
// Each request transfer carries a target ring position and is one step tick.
// The tick is registered, evaluated against the ring position in one pass,
// and yields one response transfer: coil pattern, step delay, new position
// and an arrived flag. Targets beyond the ring saturate to the last position.
// The request is held in the input stage and then in the output stage, whose
// valid drives response valid; one request is taken per cycle while the
// response side keeps up.
// The csr channel writes the full-speed and ramp delays; it is always ready
// and should be used only while no tick is outstanding.
// Reset clears the position, move start and coil phase, restores the delay
// defaults and empties both stages. When the receiver stalls, the response
// holds, the input stage fills and then req_stall rises until the response
// is taken.
// ----------------------------------------------------------------------------
module stepper_ring_positioner_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [srp_pkg::POS_WIDTH-1:0]       req_target_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [srp_pkg::COIL_WIDTH-1:0]      rsp_coil_pattern,
   output logic [srp_pkg::DELAY_WIDTH-1:0]     rsp_step_delay,
   output logic [srp_pkg::POS_WIDTH-1:0]       rsp_position,
   output logic                                rsp_arrived,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srp_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [srp_pkg::DELAY_WIDTH-1:0]     csr_data
);

   srp_pkg::delay_type  full_speed_ff;
   srp_pkg::delay_type  ramp_delay_ff [srp_pkg::RAMP_DEPTH];

   logic                in_valid_ff;
   srp_pkg::pos_type    in_target_ff;

   srp_pkg::pos_type    ring_position_ff, ring_position_in;
   srp_pkg::pos_type    move_start_ff, move_start_in;
   srp_pkg::phase_type  coil_phase_ff, coil_phase_in;

   logic                out_valid_ff;
   srp_pkg::coil_type   out_coil_ff;
   srp_pkg::delay_type  out_delay_ff;
   srp_pkg::pos_type    out_position_ff;
   logic                out_arrived_ff;

   logic                out_load;
   logic                advance;
   srp_pkg::pos_type    target_sat;
   logic                arrived_c;
   logic                cur_above;
   logic                down;
   srp_pkg::pos_type    dist_start;
   srp_pkg::pos_type    dist_target;
   srp_pkg::pos_type    dist_min;
   srp_pkg::delay_type  delay_c;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_speed_ff <= srp_pkg::FULL_SPEED_RESET;
         for (int i = 0; i < srp_pkg::RAMP_DEPTH; i++) begin
            ramp_delay_ff[i] <= srp_pkg::RAMP_RESET[i];
         end
      end else if (csr_valid && csr_ready) begin
         case (srp_pkg::csr_index_type'(csr_index))
            srp_pkg::CSR_FULL_SPEED_DELAY: full_speed_ff    <= csr_data;
            srp_pkg::CSR_RAMP_DELAY_0:     ramp_delay_ff[0] <= csr_data;
            srp_pkg::CSR_RAMP_DELAY_1:     ramp_delay_ff[1] <= csr_data;
            srp_pkg::CSR_RAMP_DELAY_2:     ramp_delay_ff[2] <= csr_data;
            srp_pkg::CSR_RAMP_DELAY_3:     ramp_delay_ff[3] <= csr_data;
            srp_pkg::CSR_RAMP_DELAY_4:     ramp_delay_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_target_ff <= req_target_position;
      end
   end

   always_comb begin
      target_sat = (in_target_ff > srp_pkg::LAST_POS) ? srp_pkg::LAST_POS : in_target_ff;
      arrived_c  = (ring_position_ff == target_sat);
      cur_above  = (ring_position_ff > target_sat);
      if (srp_pkg::abs_gap(ring_position_ff, target_sat) <= srp_pkg::HALF_TURN) begin
         down = cur_above;
      end else begin
         down = !cur_above;
      end

      ring_position_in = ring_position_ff;
      coil_phase_in    = coil_phase_ff;
      move_start_in    = move_start_ff;
      if (arrived_c) begin
         move_start_in = ring_position_ff;
      end else if (down) begin
         coil_phase_in    = coil_phase_ff - 1'b1;
         ring_position_in = (ring_position_ff == '0) ? srp_pkg::LAST_POS
                                                     : ring_position_ff - 1'b1;
      end else begin
         coil_phase_in    = coil_phase_ff + 1'b1;
         ring_position_in = (ring_position_ff == srp_pkg::LAST_POS) ? '0
                                                                    : ring_position_ff + 1'b1;
      end

      dist_start  = srp_pkg::folded_distance(ring_position_in, move_start_ff);
      dist_target = srp_pkg::folded_distance(ring_position_in, target_sat);
      dist_min    = (dist_start < dist_target) ? dist_start : dist_target;
      if (arrived_c) begin
         delay_c = '0;
      end else if (dist_min < srp_pkg::pos_type'(srp_pkg::RAMP_LENGTH)) begin
         delay_c = ramp_delay_ff[dist_min[srp_pkg::RAMP_IDX_WIDTH-1:0]];
      end else begin
         delay_c = full_speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_position_ff <= '0;
         move_start_ff    <= '0;
         coil_phase_ff    <= '0;
      end else if (advance) begin
         ring_position_ff <= ring_position_in;
         move_start_ff    <= move_start_in;
         coil_phase_ff    <= coil_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_coil_ff     <= srp_pkg::coil_pattern(coil_phase_in);
         out_delay_ff    <= delay_c;
         out_position_ff <= ring_position_in;
         out_arrived_ff  <= arrived_c;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_coil_pattern = out_coil_ff;
   assign rsp_step_delay   = out_delay_ff;
   assign rsp_position     = out_position_ff;
   assign rsp_arrived      = out_arrived_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input stage");

   a_arrived_no_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |-> (rsp_step_delay == '0))
      else $error("arrived response carries a delay");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= srp_pkg::LAST_POS))
      else $error("response position off the ring");

   a_step_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && !arrived_c) |=> (ring_position_ff != $past(ring_position_ff)))
      else $error("step tick left the position unchanged");

   a_arrived_on_target: assert property (@(posedge clock) disable iff (reset)
      (advance && arrived_c) |=> (rsp_position == $past(target_sat)))
      else $error("arrived response off target");

endmodule
